[rtl/core/ism_pkg.sv]
package ism_pkg;

  localparam int MAX_SPANS = 64;
  localparam int IDX_W = $clog2(MAX_SPANS);
  localparam int CNT_W = $clog2(MAX_SPANS + 1);
  localparam logic [32:0] WORD_BYTES = 33'd4;
  localparam logic [32:0] ADDR_LIMIT = 33'h1_0000_0000;

  localparam logic [2:0] ST_FOUND   = 3'd0;
  localparam logic [2:0] ST_NOMODEL = 3'd1;
  localparam logic [2:0] ST_CROSS   = 3'd2;
  localparam logic [2:0] ST_RUNTIME = 3'd3;
  localparam logic [2:0] ST_PAINTED = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  localparam logic [1:0] KIND_RUNTIME = 2'd1;
  localparam logic       CMD_PAINT  = 1'b0;

  typedef struct packed {
    logic        command;
    logic [31:0] address;
    logic [31:0] span_size;
    logic [1:0]  span_kind;
    logic [31:0] source_start;
    logic [31:0] span_base;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] base_offset;
    logic [31:0] source_address;
    logic [1:0]  found_kind;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start;
    logic [32:0] stop;
    logic [1:0]  kind;
    logic [31:0] source;
    logic [31:0] base;
  } span_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic scan_clr;  // reset read index, place the painted span
    logic rd;        // read one entry (pass A or B/lookup)
    logic pass_b;    // second pass
    logic copy_clr;  // reset copy index
    logic copy;      // move one scratch entry into the table
    logic finish;    // build the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_paint;
    logic zero_size;
    logic scan_done;
    logic overflow;
    logic copy_done;
  } dp_sts_t;

endpackage

[rtl/core/ism_ctrl.sv]
module ism_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output ism_pkg::dp_cmd_t cmd,
  input  ism_pkg::dp_sts_t sts,
  output logic             done
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_PASSA = 7'b0000100,
    S_PASSB = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_COPY  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_paint && sts.zero_size) state_nxt = S_DONE;
        else                               state_nxt = S_PASSA;
      end
      S_PASSA: begin
        if (sts.scan_done) begin
          cmd.scan_clr = 1'b1;
          state_nxt = sts.is_paint ? S_PASSB : S_DONE;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      S_PASSB: begin
        if (sts.scan_done) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.rd = 1'b1;
          cmd.pass_b = 1'b1;
        end
      end
      S_CHECK: begin
        cmd.copy_clr = 1'b1;
        state_nxt = sts.overflow ? S_DONE : S_COPY;
      end
      S_COPY: begin
        if (sts.copy_done) state_nxt = S_DONE;
        else               cmd.copy = 1'b1;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !busy) else $error("done not followed by idle");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not start");

endmodule

[rtl/core/ism_dp.sv]
module ism_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ism_pkg::in_item_t   in_item,
  input  ism_pkg::dp_cmd_t    cmd,
  output ism_pkg::dp_sts_t    sts,
  output ism_pkg::out_item_t  out_item
);

  // Live table and scratch table; each pass reads one entry per cycle.
  // Reads are registered and addressed by the next index, so the read
  // register always holds the entry at the current index.
  ism_pkg::span_t tbl_mem [ism_pkg::MAX_SPANS];
  ism_pkg::span_t scr_mem [ism_pkg::MAX_SPANS];

  ism_pkg::in_item_t          req_r;
  logic [32:0]                pe_r;
  logic [ism_pkg::CNT_W-1:0]  count_r;
  logic [ism_pkg::CNT_W-1:0]  ridx_r;
  logic [ism_pkg::CNT_W-1:0]  ridx_nxt;
  logic [ism_pkg::CNT_W:0]    n_r;     // may reach MAX_SPANS+2
  logic                       ovf;
  logic [ism_pkg::CNT_W-1:0]  cidx_r;
  logic [ism_pkg::CNT_W-1:0]  cidx_nxt;
  logic                       hit_r;
  ism_pkg::span_t             hit_span_r;
  ism_pkg::out_item_t         out_r;
  ism_pkg::span_t             rd_span_r;
  ism_pkg::span_t             scr_rd_r;

  ism_pkg::span_t wr_span;
  logic           wr_en;
  logic [32:0]    ns;

  always_comb begin
    ridx_nxt = ridx_r;
    if (cmd.load || cmd.scan_clr || cmd.copy_clr) ridx_nxt = '0;
    else if (cmd.rd)                              ridx_nxt = ridx_r + 1'b1;
    cidx_nxt = cidx_r;
    if (cmd.copy_clr)  cidx_nxt = '0;
    else if (cmd.copy) cidx_nxt = cidx_r + 1'b1;
  end

  always_comb begin
    wr_span = rd_span_r;
    wr_en = 1'b0;
    ns = '0;
    if (!cmd.pass_b) begin
      if (rd_span_r.start < req_r.address) begin
        wr_en = 1'b1;
        if (rd_span_r.stop > {1'b0, req_r.address}) wr_span.stop = {1'b0, req_r.address};
      end
    end else begin
      ns = ({1'b0, rd_span_r.start} > pe_r) ? {1'b0, rd_span_r.start} : pe_r;
      if (rd_span_r.stop > pe_r && ns < ism_pkg::ADDR_LIMIT) begin
        wr_en = 1'b1;
        wr_span.start = ns[31:0];
      end
    end
  end

  // Write one scratch entry; drop it once the count is past the table.
  always_ff @(posedge clk) begin
    rd_span_r <= tbl_mem[ridx_nxt[ism_pkg::IDX_W-1:0]];
    scr_rd_r  <= scr_mem[cidx_nxt[ism_pkg::IDX_W-1:0]];
    if (cmd.rd && req_r.command == ism_pkg::CMD_PAINT && wr_en
        && n_r < (ism_pkg::CNT_W + 1)'(ism_pkg::MAX_SPANS))
      scr_mem[n_r[ism_pkg::IDX_W-1:0]] <= wr_span;
    else if (cmd.scan_clr && req_r.command == ism_pkg::CMD_PAINT
             && n_r < (ism_pkg::CNT_W + 1)'(ism_pkg::MAX_SPANS))
      scr_mem[n_r[ism_pkg::IDX_W-1:0]] <=
        '{start: req_r.address, stop: pe_r, kind: req_r.span_kind,
          source: req_r.source_start, base: req_r.span_base};
    if (cmd.copy)
      tbl_mem[cidx_r[ism_pkg::IDX_W-1:0]] <= scr_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ridx_r  <= '0;
      n_r     <= '0;
      cidx_r  <= '0;
      hit_r   <= 1'b0;
    end else begin
      ridx_r <= ridx_nxt;
      if (cmd.load) begin
        req_r  <= in_item;
        pe_r   <= {1'b0, in_item.address} + {1'b0, in_item.span_size};
        n_r    <= '0;
        hit_r  <= 1'b0;
      end else if (cmd.scan_clr) begin
        // end of pass A: place the painted span
        if (req_r.command == ism_pkg::CMD_PAINT) n_r <= n_r + 1'b1;
      end else if (cmd.rd) begin
        if (req_r.command == ism_pkg::CMD_PAINT) begin
          if (wr_en) n_r <= n_r + 1'b1;
        end else if (rd_span_r.start <= req_r.address) begin
          hit_r <= 1'b1;
          hit_span_r <= rd_span_r;
        end
      end
      cidx_r <= cidx_nxt;
      if (cmd.copy && (cidx_r + 1'b1) == n_r[ism_pkg::CNT_W-1:0])
        count_r <= n_r[ism_pkg::CNT_W-1:0];
    end
  end

  assign ovf = n_r > (ism_pkg::CNT_W + 1)'(ism_pkg::MAX_SPANS);

  // Result assembly.
  logic [32:0] wend;
  logic [31:0] off;
  always_comb begin
    wend = {1'b0, req_r.address} + ism_pkg::WORD_BYTES;
    off  = req_r.address - hit_span_r.base;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= '0;
      if (req_r.command == ism_pkg::CMD_PAINT) begin
        out_r.status <= ovf ? ism_pkg::ST_FULL : ism_pkg::ST_PAINTED;
      end else if (!hit_r) begin
        out_r.status <= ism_pkg::ST_NOMODEL;
      end else if (wend > hit_span_r.stop) begin
        out_r.status <= ({1'b0, req_r.address} < hit_span_r.stop) ?
                        ism_pkg::ST_CROSS : ism_pkg::ST_NOMODEL;
      end else if (hit_span_r.kind == ism_pkg::KIND_RUNTIME) begin
        out_r.status      <= ism_pkg::ST_RUNTIME;
        out_r.base_offset <= off;
        out_r.found_kind  <= ism_pkg::KIND_RUNTIME;
      end else begin
        out_r.status         <= ism_pkg::ST_FOUND;
        out_r.base_offset    <= off;
        out_r.source_address <= hit_span_r.source + off;
        out_r.found_kind     <= hit_span_r.kind;
      end
    end
  end

  assign out_item = out_r;
  assign sts.is_paint  = (req_r.command == ism_pkg::CMD_PAINT);
  assign sts.zero_size = (req_r.span_size == '0);
  assign sts.scan_done = (ridx_r == count_r);
  assign sts.overflow  = ovf;
  assign sts.copy_done = (cidx_r == n_r[ism_pkg::CNT_W-1:0]);

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ism_pkg::CNT_W'(ism_pkg::MAX_SPANS)) else $error("count past table");
  a_ridx: assert property (@(posedge clk) disable iff (!rst_n)
    ridx_r <= count_r) else $error("read index past count");
  a_copy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy |-> !ovf) else $error("copy after overflow");

endmodule

[rtl/core/interval_span_map.sv]
// interval_span_map: sorted table of address spans with paint and lookup.
// Steps: a lookup scans the table once; a paint runs pass A, pass B and,
//   unless the table is full, the copy back; a zero-size paint skips them all.
// Throughput: one item at a time; busy drops with the result strobe, so the
//   next transfer can land in the same cycle as the strobe.
// Reset (synchronous, rst_n low) empties the table; the receiver cannot stall.
module interval_span_map (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ism_pkg::in_item_t  in_item,
  output logic               out_valid,
  output ism_pkg::out_item_t out_item
);

  ism_pkg::dp_cmd_t cmd;
  ism_pkg::dp_sts_t sts;
  logic             done;
  logic             out_valid_r;

  // Controller sequences the passes: pass A copies pieces before the paint,
  // then the painted span, pass B pieces after; then commit by copying back if it fits.
  ism_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts),
    .done  (done)
  );

  ism_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  // Strobe the result transfer for one cycle after the finish step.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= done;
  end
  assign out_valid = out_valid_r;

endmodule
